/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the RTL of the report coalescing arbiter.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define HRCA_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Implication whose consequence is checked in the cycle after the antecedent.
`define HRCA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/hrca_pkg.sv */
// ----------------------------------------------------------------------------
// hrca_pkg
// Types and constants of the HID report coalescing arbiter.
// ----------------------------------------------------------------------------
package hrca_pkg;

   localparam logic [1:0] KIND_KEYBOARD = 2'd0;
   localparam logic [1:0] KIND_CONSUMER = 2'd1;
   localparam logic [1:0] KIND_MOUSE    = 2'd2;
   localparam logic [1:0] KIND_READY    = 2'd3;

   localparam logic [1:0] TAG_KEYBOARD = 2'd1;
   localparam logic [1:0] TAG_CONSUMER = 2'd2;
   localparam logic [1:0] TAG_MOUSE    = 2'd3;

   localparam int KB_BYTES    = 8;
   localparam int CONS_BYTES  = 12;
   localparam int MOUSE_BYTES = 9;

   localparam logic [3:0] LEN_KEYBOARD = 4'(KB_BYTES + 1);
   localparam logic [3:0] LEN_CONSUMER = 4'(CONS_BYTES + 1);
   localparam logic [3:0] LEN_MOUSE    = 4'(MOUSE_BYTES + 1);

   localparam logic [15:0] SAT_MAX = 16'h7FFF;
   localparam logic [15:0] SAT_MIN = 16'h8000;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] byte_count;
      logic [63:0] bytes_low;
      logic [31:0] bytes_high;
   } req_type;

   typedef struct packed {
      logic [1:0]  report_tag;
      logic [63:0] body_low;
      logic [31:0] body_high;
      logic [3:0]  total_length;
   } rsp_type;

   typedef struct packed {
      logic [63:0]      keyboard_store;
      logic [95:0]      consumer_store;
      logic [7:0]       button_state;
      logic [3:0][31:0] delta_sums;
      logic [2:0]       dirty_marks;
      logic             endpoint_ready;
   } state_type;

   function automatic logic [15:0] sat16(input logic [31:0] v);
      logic [15:0] r;
      r = v[15:0];
      if (!v[31] && (v[30:15] != 16'h0000)) begin
         r = SAT_MAX;
      end else if (v[31] && (v[30:15] != 16'hFFFF)) begin
         r = SAT_MIN;
      end
      return r;
   endfunction

endpackage

/* rtl/core/hrca_stream_if.sv */
// ----------------------------------------------------------------------------
// hrca_stream_if
// Valid/ready channel carrying one transaction payload.
// ----------------------------------------------------------------------------
interface hrca_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/core/hrca_update.sv */
// ----------------------------------------------------------------------------
// hrca_update
// Coalesces one transaction into the pending reports and picks the output.
// ----------------------------------------------------------------------------
module hrca_update (
   input  hrca_pkg::state_type cur,
   input  hrca_pkg::req_type   item,
   output hrca_pkg::state_type nxt,
   output logic                res_valid,
   output hrca_pkg::rsp_type   res
);

   hrca_pkg::state_type mid;
   logic [15:0]         dx;
   logic [15:0]         dy;
   logic [15:0]         dsy;
   logic [15:0]         dsx;
   logic [3:0][15:0]    sat;
   logic [95:0]         cons_in;

   assign dx      = item.bytes_low[23:8];
   assign dy      = item.bytes_low[39:24];
   assign dsy     = item.bytes_low[55:40];
   assign dsx     = {item.bytes_high[7:0], item.bytes_low[63:56]};
   assign cons_in = {item.bytes_high, item.bytes_low};

   always_comb begin
      mid = cur;
      case (item.kind)
         hrca_pkg::KIND_KEYBOARD: begin
            for (int i = 0; i < hrca_pkg::KB_BYTES; i++) begin
               if (item.byte_count > 16'(i)) begin
                  mid.keyboard_store[8*i +: 8] = item.bytes_low[8*i +: 8];
               end
            end
            mid.dirty_marks[0] = 1'b1;
         end
         hrca_pkg::KIND_CONSUMER: begin
            for (int i = 0; i < hrca_pkg::CONS_BYTES; i++) begin
               if (item.byte_count > 16'(i)) begin
                  mid.consumer_store[8*i +: 8] = cons_in[8*i +: 8];
               end
            end
            mid.dirty_marks[1] = 1'b1;
         end
         hrca_pkg::KIND_MOUSE: begin
            if (item.byte_count >= 16'(hrca_pkg::MOUSE_BYTES)) begin
               mid.button_state  = item.bytes_low[7:0];
               mid.delta_sums[0] = cur.delta_sums[0] + {{16{dx[15]}}, dx};
               mid.delta_sums[1] = cur.delta_sums[1] + {{16{dy[15]}}, dy};
               mid.delta_sums[2] = cur.delta_sums[2] + {{16{dsy[15]}}, dsy};
               mid.delta_sums[3] = cur.delta_sums[3] + {{16{dsx[15]}}, dsx};
               mid.dirty_marks[2] = 1'b1;
            end
         end
         hrca_pkg::KIND_READY: begin
            mid.endpoint_ready = 1'b1;
         end
         default: begin
            mid = cur;
         end
      endcase
   end

   always_comb begin
      for (int j = 0; j < 4; j++) begin
         sat[j] = hrca_pkg::sat16(mid.delta_sums[j]);
      end
   end

   always_comb begin
      nxt       = mid;
      res_valid = 1'b0;
      res       = '0;
      if (mid.endpoint_ready) begin
         if (mid.dirty_marks[0]) begin
            res_valid            = 1'b1;
            nxt.dirty_marks[0]   = 1'b0;
            res.report_tag       = hrca_pkg::TAG_KEYBOARD;
            res.body_low         = mid.keyboard_store;
            res.body_high        = '0;
            res.total_length     = hrca_pkg::LEN_KEYBOARD;
         end else if (mid.dirty_marks[1]) begin
            res_valid            = 1'b1;
            nxt.dirty_marks[1]   = 1'b0;
            res.report_tag       = hrca_pkg::TAG_CONSUMER;
            res.body_low         = mid.consumer_store[63:0];
            res.body_high        = mid.consumer_store[95:64];
            res.total_length     = hrca_pkg::LEN_CONSUMER;
         end else if (mid.dirty_marks[2]) begin
            res_valid            = 1'b1;
            nxt.dirty_marks[2]   = 1'b0;
            nxt.delta_sums       = '0;
            res.report_tag       = hrca_pkg::TAG_MOUSE;
            res.body_low         = {sat[3][7:0], sat[2], sat[1], sat[0], mid.button_state};
            res.body_high        = {24'h000000, sat[3][15:8]};
            res.total_length     = hrca_pkg::LEN_MOUSE;
         end
         if (res_valid) begin
            nxt.endpoint_ready = 1'b0;
         end
      end
   end

endmodule

/* rtl/core/hid_report_coalescing_arbiter_top.sv */
// ----------------------------------------------------------------------------
// hid_report_coalescing_arbiter_top
// Coalesces keyboard, consumer and mouse HID reports while the endpoint is
// busy and emits the highest-priority pending report once it is ready.
//
//   channel   | dir | payload              | handshake
//   ----------+-----+----------------------+--------------------------
//   req_chan  | in  | hrca_pkg::req_type   | valid/ready, sink
//   rsp_chan  | out | hrca_pkg::rsp_type   | valid/ready, source
//
// One transaction per cycle when not stalled: input register, one update/pick
// pass, result register; a result is registered from the request register.
// Synchronous reset clears all pending reports, sums and the ready flag.
// A stalled result register holds a full request register, which in turn
// deasserts req_chan.ready; otherwise both advance every cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hid_report_coalescing_arbiter_top (
   input  logic                 clock,
   input  logic                 reset,
   hrca_stream_if.sink          req_chan,
   hrca_stream_if.source        rsp_chan
);

   hrca_pkg::req_type   req_ff;
   logic                req_valid_ff;
   logic                req_valid_in;
   hrca_pkg::state_type state_ff;
   hrca_pkg::state_type state_in;
   hrca_pkg::rsp_type   rsp_ff;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   hrca_pkg::rsp_type   res;
   logic                res_valid;
   logic                advance;
   logic                req_fire;
   logic                step;

   assign advance        = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !req_valid_ff || advance;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign step           = req_valid_ff && advance;

   hrca_update u_update (
      .cur       (state_ff),
      .item      (req_ff),
      .nxt       (state_in),
      .res_valid (res_valid),
      .res       (res)
   );

   always_comb begin
      req_valid_in = req_valid_ff;
      if (req_fire) begin
         req_valid_in = 1'b1;
      end else if (advance) begin
         req_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = step && res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (step) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         req_ff <= req_chan.payload;
      end
      if (step) begin
         rsp_ff <= res;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

   `HRCA_ASSERT_IMP(a_len_matches_tag, clock, reset, rsp_valid_ff,
      (rsp_ff.report_tag == hrca_pkg::TAG_KEYBOARD &&
       rsp_ff.total_length == hrca_pkg::LEN_KEYBOARD) ||
      (rsp_ff.report_tag == hrca_pkg::TAG_CONSUMER &&
       rsp_ff.total_length == hrca_pkg::LEN_CONSUMER) ||
      (rsp_ff.report_tag == hrca_pkg::TAG_MOUSE &&
       rsp_ff.total_length == hrca_pkg::LEN_MOUSE), "tag and length disagree")
   `HRCA_ASSERT_NEXT(a_busy_after_emit, clock, reset, step && res_valid,
      !state_ff.endpoint_ready && rsp_valid_ff, "endpoint not busy after emit")
   `HRCA_ASSERT_IMP(a_no_emit_while_busy, clock, reset,
      step && !state_ff.endpoint_ready && req_ff.kind != hrca_pkg::KIND_READY,
      !res_valid, "report emitted while endpoint busy")
   `HRCA_ASSERT_NEXT(a_mouse_sums_cleared, clock, reset,
      step && res_valid && res.report_tag == hrca_pkg::TAG_MOUSE,
      state_ff.delta_sums == '0 && !state_ff.dirty_marks[2], "mouse sums kept")

endmodule

/* dv/hrca_report_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrca_report_checker
// Watches both channels of the report coalescing arbiter, keeps its own copy
// of the pending reports, mouse sums and endpoint flag, predicts the report
// each request causes and compares every emitted report field by field.
// ----------------------------------------------------------------------------
module hrca_report_checker
   import hrca_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_payload,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_payload,
   output int      mismatches,
   output int      outstanding,
   output int      reports_seen
);

   logic [63:0] kb_copy;
   logic [95:0] cons_copy;
   logic [7:0]  mouse_buttons;
   logic [31:0] motion_sum [4];
   logic [2:0]  pending_marks;
   logic        endpoint_free;
   rsp_type     report_queue [$];

   function automatic logic [15:0] clamp16(input logic [31:0] v);
      if ($signed(v) > 32'sd32767) begin
         return SAT_MAX;
      end else if ($signed(v) < -32'sd32768) begin
         return SAT_MIN;
      end
      return v[15:0];
   endfunction

   task automatic coalesce_and_pick(input req_type item);
      rsp_type     report;
      logic [95:0] incoming;
      logic [15:0] wheel_h;
      logic [15:0] clamped [4];
      incoming = {item.bytes_high, item.bytes_low};
      case (item.kind)
         KIND_KEYBOARD: begin
            for (int i = 0; i < KB_BYTES; i++) begin
               if (i < item.byte_count) kb_copy[8*i +: 8] = item.bytes_low[8*i +: 8];
            end
            pending_marks[0] = 1'b1;
         end
         KIND_CONSUMER: begin
            for (int i = 0; i < CONS_BYTES; i++) begin
               if (i < item.byte_count) cons_copy[8*i +: 8] = incoming[8*i +: 8];
            end
            pending_marks[1] = 1'b1;
         end
         KIND_MOUSE: begin
            if (item.byte_count >= MOUSE_BYTES) begin
               wheel_h = {item.bytes_high[7:0], item.bytes_low[63:56]};
               mouse_buttons = item.bytes_low[7:0];
               motion_sum[0] = motion_sum[0]
                  + {{16{item.bytes_low[23]}}, item.bytes_low[23:8]};
               motion_sum[1] = motion_sum[1]
                  + {{16{item.bytes_low[39]}}, item.bytes_low[39:24]};
               motion_sum[2] = motion_sum[2]
                  + {{16{item.bytes_low[55]}}, item.bytes_low[55:40]};
               motion_sum[3] = motion_sum[3] + {{16{wheel_h[15]}}, wheel_h};
               pending_marks[2] = 1'b1;
            end
         end
         default: begin
            endpoint_free = 1'b1;
         end
      endcase

      if (endpoint_free && pending_marks != 3'b000) begin
         if (pending_marks[0]) begin
            pending_marks[0]    = 1'b0;
            report.report_tag   = TAG_KEYBOARD;
            report.body_low     = kb_copy;
            report.body_high    = 32'd0;
            report.total_length = LEN_KEYBOARD;
         end else if (pending_marks[1]) begin
            pending_marks[1]    = 1'b0;
            report.report_tag   = TAG_CONSUMER;
            report.body_low     = cons_copy[63:0];
            report.body_high    = cons_copy[95:64];
            report.total_length = LEN_CONSUMER;
         end else begin
            pending_marks[2] = 1'b0;
            for (int i = 0; i < 4; i++) begin
               clamped[i]    = clamp16(motion_sum[i]);
               motion_sum[i] = 32'd0;
            end
            report.report_tag   = TAG_MOUSE;
            report.body_low     = {clamped[3][7:0], clamped[2], clamped[1], clamped[0],
                                   mouse_buttons};
            report.body_high    = {24'd0, clamped[3][15:8]};
            report.total_length = LEN_MOUSE;
         end
         endpoint_free = 1'b0;
         report_queue.push_back(report);
      end
   endtask

   task automatic check_report(input rsp_type got);
      rsp_type want;
      if (report_queue.size() == 0) begin
         $error("report_tag: expected no report, got %0d", got.report_tag);
         mismatches++;
      end else begin
         want = report_queue.pop_front();
         if (got.report_tag !== want.report_tag) begin
            $error("report_tag: expected %0d, got %0d", want.report_tag, got.report_tag);
            mismatches++;
         end
         if (got.body_low !== want.body_low) begin
            $error("body_low: expected %h, got %h", want.body_low, got.body_low);
            mismatches++;
         end
         if (got.body_high !== want.body_high) begin
            $error("body_high: expected %h, got %h", want.body_high, got.body_high);
            mismatches++;
         end
         if (got.total_length !== want.total_length) begin
            $error("total_length: expected %0d, got %0d", want.total_length,
                   got.total_length);
            mismatches++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         kb_copy       = '0;
         cons_copy     = '0;
         mouse_buttons = '0;
         for (int i = 0; i < 4; i++) motion_sum[i] = '0;
         pending_marks = '0;
         endpoint_free = 1'b0;
         report_queue.delete();
         mismatches    = 0;
         reports_seen  = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            check_report(rsp_payload);
            reports_seen++;
         end
         if (req_valid && req_ready) coalesce_and_pick(req_payload);
      end
      outstanding = report_queue.size();
   end

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives the report coalescing arbiter with a directed run of edge cases
// (partial and oversized reports, short mouse reports, saturating sums,
// repeated ready events) and then random traffic under four pacing phases.
// A checker module beside the block predicts and compares every report.
// ----------------------------------------------------------------------------
module tb;
   import hrca_pkg::*;

   localparam int RANDOM_REQUESTS = 850;

   logic clock;
   logic reset;
   int   mismatches;
   int   outstanding;
   int   reports_seen;
   int   send_idle_pct;
   int   recv_stall_pct;
   int   requests_sent;

   hrca_stream_if #(.payload_type(req_type)) req_if ();
   hrca_stream_if #(.payload_type(rsp_type)) rsp_if ();

   hid_report_coalescing_arbiter_top uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   hrca_report_checker report_check (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_if.valid),
      .req_ready    (req_if.ready),
      .req_payload  (req_if.payload),
      .rsp_valid    (rsp_if.valid),
      .rsp_ready    (rsp_if.ready),
      .rsp_payload  (rsp_if.payload),
      .mismatches   (mismatches),
      .outstanding  (outstanding),
      .reports_seen (reports_seen)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   initial begin
      #(64'd500000 * 12);
      $display("tb: FAIL");
      $finish;
   end

   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   function automatic req_type request_of(input logic [1:0] kind, input logic [15:0] count,
                                          input logic [63:0] lo, input logic [31:0] hi);
      req_type item;
      item.kind       = kind;
      item.byte_count = count;
      item.bytes_low  = lo;
      item.bytes_high = hi;
      return item;
   endfunction

   function automatic logic [15:0] report_length(input int nominal);
      case ($urandom_range(9))
         6, 7:    return 16'($urandom_range(nominal));
         8:       return 16'($urandom_range(64, nominal));
         9:       return 16'($urandom_range(65535));
         default: return 16'(nominal);
      endcase
   endfunction

   function automatic req_type random_request();
      req_type     item;
      int          roll;
      logic [15:0] delta [4];
      roll = $urandom_range(99);
      item = request_of(KIND_READY, 16'($urandom_range(65535)),
                        {$urandom, $urandom}, $urandom);
      if (roll < 25) begin
         item.kind = KIND_READY;
      end else if (roll < 45) begin
         item.kind       = KIND_KEYBOARD;
         item.byte_count = report_length(KB_BYTES);
      end else if (roll < 65) begin
         item.kind       = KIND_CONSUMER;
         item.byte_count = report_length(CONS_BYTES);
      end else if (roll < 90) begin
         item.kind       = KIND_MOUSE;
         item.byte_count = report_length(MOUSE_BYTES);
         if ($urandom_range(1) == 1) begin
            for (int i = 0; i < 4; i++) delta[i] = 16'($urandom_range(40)) - 16'd20;
            item.bytes_low[63:8]  = {delta[3][7:0], delta[2], delta[1], delta[0]};
            item.bytes_high[7:0]  = delta[3][15:8];
         end
      end else begin
         item.kind = 2'($urandom_range(3));
      end
      return item;
   endfunction

   task automatic drive_request(input req_type item);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= item;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      requests_sent++;
   endtask

   initial begin
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      reset          = 1'b1;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      requests_sent  = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // edge cases, no pacing
      drive_request(request_of(KIND_KEYBOARD, 16'd0, '1, '0));
      drive_request(request_of(KIND_READY, 16'd0, '0, '0));
      drive_request(request_of(KIND_KEYBOARD, 16'd8, '1, '0));
      drive_request(request_of(KIND_CONSUMER, 16'd12, '1, '1));
      drive_request(request_of(KIND_MOUSE, 16'd8, '1, '1));
      drive_request(request_of(KIND_MOUSE, 16'd9, 64'h00_7FFF_8000_7FFF_A5,
                               32'hFFFF_FF80));
      drive_request(request_of(KIND_MOUSE, 16'hFFFF, 64'hFF_0001_8000_7FFF_5A,
                               32'h0000_00FF));
      drive_request(request_of(KIND_READY, 16'd0, '0, '0));
      drive_request(request_of(KIND_READY, 16'd0, '0, '0));
      drive_request(request_of(KIND_READY, 16'd0, '0, '0));
      drive_request(request_of(KIND_READY, 16'd0, '0, '0));
      drive_request(request_of(KIND_READY, 16'hFFFF, '1, '1));
      drive_request(request_of(KIND_KEYBOARD, 16'd3, 64'h0123_4567_89AB_CDEF, '1));
      drive_request(request_of(KIND_READY, 16'd0, '0, '0));
      drive_request(request_of(KIND_CONSUMER, 16'd5, '0, '0));
      drive_request(request_of(KIND_READY, 16'd0, '0, '0));
      drive_request(request_of(KIND_CONSUMER, 16'd20, 64'hAAAA_AAAA_AAAA_AAAA,
                               32'h5555_5555));
      drive_request(request_of(KIND_READY, 16'd0, '0, '0));
      drive_request(request_of(KIND_KEYBOARD, 16'd100, 64'h5555_5555_5555_5555, '1));
      drive_request(request_of(KIND_READY, 16'd0, '0, '0));
      drive_request(request_of(KIND_MOUSE, 16'd9, 64'h02_FF00_0003_FFFE_00,
                               32'h0000_0001));
      drive_request(request_of(KIND_READY, 16'd0, '0, '0));
      drive_request(request_of(KIND_MOUSE, 16'd0, '1, '1));
      drive_request(request_of(KIND_CONSUMER, 16'd0, '1, '1));

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct  = 63;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 63;
            end
            default: begin
               send_idle_pct  = 9;
               recv_stall_pct = 9;
            end
         endcase
         repeat (RANDOM_REQUESTS / 4) drive_request(random_request());
      end

      @(negedge clock);
      req_if.valid <= 1'b0;
      while (outstanding != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("tb: %0d requests driven, %0d reports checked over four pacing phases",
               requests_sent, reports_seen);
      if (mismatches == 0 && outstanding == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule
